/* hdl/igfr_pkg.sv */
// ----------------------------------------------------------------------------
// igfr_pkg
// Shared types and constants of the idle-gap frame ring receiver.
// ----------------------------------------------------------------------------
package igfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 8;
    localparam int GAP_W      = 4;
    localparam int CMDQ_DEPTH = 4;

    localparam logic [GAP_W-1:0] GAP_RESET = 4'd2;

    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_POP  = 2'd2;

    typedef enum logic [1:0] {
        CMD_BYTE,
        CMD_CLOSE,
        CMD_POP
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t             op;
        logic                rcv;
        logic [LEN_W-1:0]    len;
        logic [BYTE_W-1:0]   data;
    } cmd_t;

endpackage

/* hdl/igfr_front.sv */
// ----------------------------------------------------------------------------
// igfr_front
// Accepts input items, tracks reception and the idle gap, and issues commands.
// ----------------------------------------------------------------------------
module igfr_front #(
    parameter int FRAME_BYTES = 128
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  opcode,
    input  logic [igfr_pkg::BYTE_W-1:0] rx_byte,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [igfr_pkg::GAP_W-1:0]  cfg_data,
    output logic                        q_push,
    output igfr_pkg::cmd_t              q_din,
    input  logic                        q_full
);
    import igfr_pkg::*;

    logic [GAP_W-1:0] gap_ticks_reg;
    logic             receiving_reg;
    logic             receiving_next;
    logic [GAP_W-1:0] gap_reg;
    logic [GAP_W-1:0] gap_next;
    logic [GAP_W-1:0] gap_dec;
    logic [LEN_W-1:0] count_reg;
    logic [LEN_W-1:0] count_next;
    logic             accept;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign accept    = push && !q_full;
    assign gap_dec   = (gap_reg != '0) ? gap_reg - GAP_W'(1) : '0;

    always_comb
    begin
        receiving_next = receiving_reg;
        gap_next       = gap_reg;
        count_next     = count_reg;
        q_push         = 1'b0;
        q_din.op       = CMD_POP;
        q_din.rcv      = receiving_reg;
        q_din.len      = count_reg;
        q_din.data     = rx_byte;
        if (accept)
        begin
            case (opcode)
                OP_BYTE:
                begin
                    receiving_next = 1'b1;
                    gap_next       = gap_ticks_reg;
                    if (count_reg < LEN_W'(FRAME_BYTES))
                    begin
                        q_push     = 1'b1;
                        q_din.op   = CMD_BYTE;
                        count_next = count_reg + LEN_W'(1);
                    end
                end
                OP_TICK:
                begin
                    if (receiving_reg)
                    begin
                        if (gap_dec == '0)
                        begin
                            q_push         = 1'b1;
                            q_din.op       = CMD_CLOSE;
                            receiving_next = 1'b0;
                            gap_next       = '0;
                            count_next     = '0;
                        end
                        else
                        begin
                            gap_next = gap_dec;
                        end
                    end
                end
                OP_POP:
                begin
                    q_push = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_ticks_reg <= GAP_RESET;
            receiving_reg <= 1'b0;
            gap_reg       <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                gap_ticks_reg <= cfg_data;
            end
            receiving_reg <= receiving_next;
            gap_reg       <= gap_next;
            count_reg     <= count_next;
        end
    end

endmodule

/* hdl/igfr_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// igfr_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module igfr_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  igfr_pkg::cmd_t din,
    output logic           full,
    input  logic           pop,
    output igfr_pkg::cmd_t dout,
    output logic           empty
);
    import igfr_pkg::*;

    localparam int PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    cmd_t             entry_reg [CMDQ_DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] tail_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(CMDQ_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = entry_reg[head_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entry_reg[tail_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                tail_reg <= tail_reg + PTR_W'(1);
            end
            if (pop && !empty)
            begin
                head_reg <= head_reg + PTR_W'(1);
            end
            if ((push && !full) && !(pop && !empty))
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (!(push && !full) && (pop && !empty))
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

/* hdl/igfr_back.sv */
// ----------------------------------------------------------------------------
// igfr_back
// Executes commands: assembly buffer writes, frame copy into the slot ring,
// and draining of the oldest frame into the result register.
// ----------------------------------------------------------------------------
module igfr_back #(
    parameter int FRAME_BYTES = 128,
    parameter int SLOTS       = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  igfr_pkg::cmd_t              cmd,
    input  logic                        cmd_empty,
    output logic                        cmd_take,
    output logic                        res_valid,
    input  logic                        res_take,
    output logic                        got_byte,
    output logic [igfr_pkg::BYTE_W-1:0] frame_byte,
    output logic                        last_of_frame
);
    import igfr_pkg::*;

    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int ASM_AW   = $clog2(FRAME_BYTES);
    localparam int SM_DEPTH = SLOTS * FRAME_BYTES;
    localparam int SM_AW    = $clog2(SM_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_POP_START,
        ST_POP_RD,
        ST_POP_OUT
    } state_t;

    logic [BYTE_W-1:0] asm_mem [FRAME_BYTES];
    logic [BYTE_W-1:0] slot_mem [SM_DEPTH];
    logic [LEN_W-1:0]  len_mem [SLOTS];

    state_t            state_reg, state_next;
    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0] read_slot_reg, read_slot_next;
    logic              drain_active_reg, drain_active_next;
    logic [SLOT_W-1:0] drain_slot_reg, drain_slot_next;
    logic [LEN_W-1:0]  drain_off_reg, drain_off_next;
    logic [LEN_W-1:0]  drain_len_reg, drain_len_next;
    logic [LEN_W-1:0]  copy_idx_reg, copy_idx_next;
    logic [LEN_W-1:0]  copy_len_reg, copy_len_next;
    logic              res_valid_reg, res_valid_next;
    logic              got_byte_reg, got_byte_next;
    logic [BYTE_W-1:0] frame_byte_reg, frame_byte_next;
    logic              last_reg, last_next;

    logic [BYTE_W-1:0] asm_rd_reg;
    logic [BYTE_W-1:0] slot_rd_reg;
    logic [LEN_W-1:0]  len_rd_reg;

    logic              out_free;
    logic              pop_none;
    logic              asm_we;
    logic              slot_we;
    logic              len_we;
    logic              copy_done;
    logic              drain_last;
    logic [SM_AW-1:0]  copy_addr;
    logic [SM_AW-1:0]  drain_addr;
    logic [SLOT_W-1:0] ws_after;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    assign out_free   = !res_valid_reg || res_take;
    assign pop_none   = cmd.rcv || !valid_reg[read_slot_reg];
    assign copy_done  = ({1'b0, copy_idx_reg} + 9'd1) == {1'b0, copy_len_reg};
    assign drain_last = ({1'b0, drain_off_reg} + 9'd1) >= {1'b0, drain_len_reg};
    assign copy_addr  = SM_AW'(write_slot_reg) * SM_AW'(FRAME_BYTES) + SM_AW'(copy_idx_reg);
    assign drain_addr = SM_AW'(drain_slot_reg) * SM_AW'(FRAME_BYTES) + SM_AW'(drain_off_reg);
    assign ws_after   = next_slot(write_slot_reg);
    assign asm_we     = (state_reg == ST_IDLE) && !cmd_empty && (cmd.op == CMD_BYTE);
    assign slot_we    = (state_reg == ST_COPY_WR);
    assign len_we     = (state_reg == ST_COPY_WR) && copy_done;

    assign res_valid     = res_valid_reg;
    assign got_byte      = got_byte_reg;
    assign frame_byte    = frame_byte_reg;
    assign last_of_frame = last_reg;

    always_ff @(posedge clk)
    begin
        if (asm_we)
        begin
            asm_mem[cmd.len[ASM_AW-1:0]] <= cmd.data;
        end
        if (state_reg == ST_COPY_RD)
        begin
            asm_rd_reg <= asm_mem[copy_idx_reg[ASM_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[copy_addr] <= asm_rd_reg;
        end
        if (state_reg == ST_POP_RD)
        begin
            slot_rd_reg <= slot_mem[drain_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[write_slot_reg] <= copy_len_reg;
        end
        len_rd_reg <= len_mem[read_slot_reg];
    end

    always_comb
    begin
        state_next        = state_reg;
        valid_next        = valid_reg;
        write_slot_next   = write_slot_reg;
        read_slot_next    = read_slot_reg;
        drain_active_next = drain_active_reg;
        drain_slot_next   = drain_slot_reg;
        drain_off_next    = drain_off_reg;
        drain_len_next    = drain_len_reg;
        copy_idx_next     = copy_idx_reg;
        copy_len_next     = copy_len_reg;
        res_valid_next    = res_valid_reg && !res_take;
        got_byte_next     = got_byte_reg;
        frame_byte_next   = frame_byte_reg;
        last_next         = last_reg;
        cmd_take          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    case (cmd.op)
                        CMD_BYTE:
                        begin
                            cmd_take = 1'b1;
                        end
                        CMD_CLOSE:
                        begin
                            cmd_take      = 1'b1;
                            copy_len_next = cmd.len;
                            copy_idx_next = '0;
                            state_next    = ST_COPY_RD;
                        end
                        CMD_POP:
                        begin
                            if (drain_active_reg)
                            begin
                                cmd_take   = 1'b1;
                                state_next = ST_POP_RD;
                            end
                            else if (pop_none)
                            begin
                                if (out_free)
                                begin
                                    cmd_take        = 1'b1;
                                    res_valid_next  = 1'b1;
                                    got_byte_next   = 1'b0;
                                    frame_byte_next = '0;
                                    last_next       = 1'b0;
                                end
                            end
                            else
                            begin
                                cmd_take   = 1'b1;
                                state_next = ST_POP_START;
                            end
                        end
                        default:
                        begin
                            cmd_take = 1'b1;
                        end
                    endcase
                end
            end
            ST_COPY_RD:
            begin
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                if (copy_done)
                begin
                    valid_next[write_slot_reg] = 1'b1;
                    write_slot_next            = ws_after;
                    if (valid_reg[ws_after])
                    begin
                        read_slot_next = ws_after;
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    copy_idx_next = copy_idx_reg + LEN_W'(1);
                    state_next    = ST_COPY_RD;
                end
            end
            ST_POP_START:
            begin
                drain_active_next         = 1'b1;
                drain_slot_next           = read_slot_reg;
                drain_len_next            = len_rd_reg;
                drain_off_next            = '0;
                valid_next[read_slot_reg] = 1'b0;
                read_slot_next            = next_slot(read_slot_reg);
                state_next                = ST_POP_RD;
            end
            ST_POP_RD:
            begin
                state_next = ST_POP_OUT;
            end
            ST_POP_OUT:
            begin
                if (out_free)
                begin
                    res_valid_next  = 1'b1;
                    got_byte_next   = 1'b1;
                    frame_byte_next = slot_rd_reg;
                    last_next       = drain_last;
                    drain_off_next  = drain_off_reg + LEN_W'(1);
                    if (drain_last)
                    begin
                        drain_active_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            valid_reg        <= '0;
            write_slot_reg   <= '0;
            read_slot_reg    <= '0;
            drain_active_reg <= 1'b0;
            drain_slot_reg   <= '0;
            drain_off_reg    <= '0;
            drain_len_reg    <= '0;
            copy_idx_reg     <= '0;
            copy_len_reg     <= '0;
            res_valid_reg    <= 1'b0;
            got_byte_reg     <= 1'b0;
            frame_byte_reg   <= '0;
            last_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            valid_reg        <= valid_next;
            write_slot_reg   <= write_slot_next;
            read_slot_reg    <= read_slot_next;
            drain_active_reg <= drain_active_next;
            drain_slot_reg   <= drain_slot_next;
            drain_off_reg    <= drain_off_next;
            drain_len_reg    <= drain_len_next;
            copy_idx_reg     <= copy_idx_next;
            copy_len_reg     <= copy_len_next;
            res_valid_reg    <= res_valid_next;
            got_byte_reg     <= got_byte_next;
            frame_byte_reg   <= frame_byte_next;
            last_reg         <= last_next;
        end
    end

endmodule

/* hdl/idle_gap_frame_ring_receiver.sv */
// ----------------------------------------------------------------------------
// idle_gap_frame_ring_receiver
// Gathers received bytes into frames closed by an idle gap of timer ticks,
// keeps closed frames in a ring of slots and drains the oldest on request.
// ----------------------------------------------------------------------------
// Bytes and ticks enter a four-entry command queue at one item per cycle unless it is full.
// A pop result is registered from the idle state when no frame is ready; otherwise it passes
// the read and output states, after a start state when the pop opens a new drain.
// Closing a frame holds the back end for a read and a write of each byte, one access a step.
// Reset clears all control state; frame and slot memories need no clearing pass.
module idle_gap_frame_ring_receiver #(
    parameter int FRAME_BYTES = 128,
    parameter int SLOTS       = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  opcode,
    input  logic [igfr_pkg::BYTE_W-1:0] rx_byte,
    output logic                        empty,
    input  logic                        pop,
    output logic                        got_byte,
    output logic [igfr_pkg::BYTE_W-1:0] frame_byte,
    output logic                        last_of_frame,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [igfr_pkg::GAP_W-1:0]  cfg_data
);
    import igfr_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    cmd_t q_din;
    cmd_t q_dout;
    logic res_valid;
    logic res_take;

    assign empty    = !res_valid;
    assign res_take = pop && res_valid;

    igfr_front #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .opcode   (opcode),
        .rx_byte  (rx_byte),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .q_push   (q_push),
        .q_din    (q_din),
        .q_full   (q_full)
    );

    igfr_cmd_fifo u_cmd_fifo (
        .clk  (clk),
        .rst_n(rst_n),
        .push (q_push),
        .din  (q_din),
        .full (q_full),
        .pop  (q_pop),
        .dout (q_dout),
        .empty(q_empty)
    );

    igfr_back #(
        .FRAME_BYTES(FRAME_BYTES),
        .SLOTS      (SLOTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (q_dout),
        .cmd_empty    (q_empty),
        .cmd_take     (q_pop),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .got_byte     (got_byte),
        .frame_byte   (frame_byte),
        .last_of_frame(last_of_frame)
    );

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !got_byte) |-> (frame_byte == '0 && !last_of_frame))
        else $error("Empty pop result carries data.");

    a_queue_push: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("Command pushed into a full queue.");

    a_queue_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("Command taken from an empty queue.");

endmodule

/* tb/igfr_frame_checker.sv */
// ----------------------------------------------------------------------------
// igfr_frame_checker
// Watches the request, result and configuration channels of the idle-gap
// frame ring receiver. It keeps its own copy of the assembly buffer, the slot
// ring and the drain state, predicts the result of every accepted drain
// request, and compares each accepted result, field by field, against the
// oldest prediction. It reports the number of failures and of results still due.
// ----------------------------------------------------------------------------
module igfr_frame_checker #(
    parameter int FRAME_BYTES = 128,
    parameter int SLOTS       = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic                        full,
    input  logic [1:0]                  opcode,
    input  logic [igfr_pkg::BYTE_W-1:0] rx_byte,
    input  logic                        empty,
    input  logic                        pop,
    input  logic                        got_byte,
    input  logic [igfr_pkg::BYTE_W-1:0] frame_byte,
    input  logic                        last_of_frame,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [igfr_pkg::GAP_W-1:0]  cfg_data,
    output int                          fail_count,
    output int                          waiting
);
    import igfr_pkg::*;

    typedef struct packed {
        logic              got;
        logic [BYTE_W-1:0] data;
        logic              last;
    } drain_byte_t;

    logic [BYTE_W-1:0] asm_buf [FRAME_BYTES];
    int                asm_count;
    bit                rx_on;
    logic [GAP_W-1:0]  gap_left;
    logic [GAP_W-1:0]  gap_cfg;
    logic [BYTE_W-1:0] ring [SLOTS*FRAME_BYTES];
    int                ring_len [SLOTS];
    int                wr_slot;
    int                rd_slot;
    bit                drain_on;
    int                drain_slot;
    int                drain_pos;
    int                drain_len;
    drain_byte_t       due_bytes [$];
    drain_byte_t       want;
    drain_byte_t       seen;
    int                errors;

    function automatic int next_ring_slot(input int s);
        return (s + 1 >= SLOTS) ? 0 : s + 1;
    endfunction

    task automatic store_frame();
        for (int i = 0; i < asm_count; i++)
            ring[wr_slot*FRAME_BYTES + i] = asm_buf[i];
        ring_len[wr_slot] = asm_count;
        rx_on     = 1'b0;
        gap_left  = '0;
        asm_count = 0;
        wr_slot   = next_ring_slot(wr_slot);
        if (ring_len[wr_slot] != 0)
            rd_slot = wr_slot;
    endtask

    task automatic apply_request(input logic [1:0] op, input logic [BYTE_W-1:0] b);
        drain_byte_t r;
        int          pos;
        r = '0;
        case (op)
            OP_BYTE:
            begin
                rx_on    = 1'b1;
                gap_left = gap_cfg;
                if (asm_count < FRAME_BYTES)
                begin
                    asm_buf[asm_count] = b;
                    asm_count++;
                end
            end
            OP_TICK:
            begin
                if (rx_on)
                begin
                    if (gap_left != 0)
                        gap_left = gap_left - 1'b1;
                    if (gap_left == 0)
                        store_frame();
                end
            end
            OP_POP:
            begin
                if (drain_on || (!rx_on && ring_len[rd_slot] != 0))
                begin
                    if (!drain_on)
                    begin
                        drain_on   = 1'b1;
                        drain_slot = rd_slot;
                        drain_len  = ring_len[rd_slot];
                        drain_pos  = 0;
                        ring_len[rd_slot] = 0;
                        rd_slot    = next_ring_slot(rd_slot);
                    end
                    pos    = (drain_pos < FRAME_BYTES) ? drain_pos : FRAME_BYTES - 1;
                    r.got  = 1'b1;
                    r.data = ring[drain_slot*FRAME_BYTES + pos];
                    r.last = (drain_pos + 1 >= drain_len);
                    drain_pos++;
                    if (r.last)
                        drain_on = 1'b0;
                end
                due_bytes.push_back(r);
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAME_BYTES; i++)
                asm_buf[i] = '0;
            for (int i = 0; i < SLOTS*FRAME_BYTES; i++)
                ring[i] = '0;
            for (int i = 0; i < SLOTS; i++)
                ring_len[i] = 0;
            asm_count  = 0;
            rx_on      = 1'b0;
            gap_left   = '0;
            gap_cfg    = GAP_RESET;
            wr_slot    = 0;
            rd_slot    = 0;
            drain_on   = 1'b0;
            drain_slot = 0;
            drain_pos  = 0;
            drain_len  = 0;
            errors     = 0;
            due_bytes.delete();
            fail_count <= 0;
            waiting    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                gap_cfg = cfg_data;
            if (push && !full)
                apply_request(opcode, rx_byte);
            if (pop && !empty)
            begin
                seen = {got_byte, frame_byte, last_of_frame};
                if (due_bytes.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result: got=%0d byte=%02h last=%0d",
                                 seen.got, seen.data, seen.last);
                    errors++;
                end
                else
                begin
                    want = due_bytes.pop_front();
                    if (seen.got !== want.got || seen.data !== want.data
                        || seen.last !== want.last)
                    begin
                        if (errors < 10)
                            $display({"mismatch: expected got=%0d byte=%02h last=%0d,",
                                      " actual got=%0d byte=%02h last=%0d"},
                                     want.got, want.data, want.last,
                                     seen.got, seen.data, seen.last);
                        errors++;
                    end
                end
            end
            fail_count <= errors;
            waiting    <= due_bytes.size();
        end
    end

endmodule

/* tb/idle_gap_frame_ring_receiver_tb.sv */
// ----------------------------------------------------------------------------
// idle_gap_frame_ring_receiver_tb
// Drives received bytes, timer ticks and drain requests into the receiver and
// takes its results with random stalls on both sides. A directed opening
// covers the corner cases; random phases under several gap settings follow,
// built mostly from whole frames, drains and ring wraps, with some noise.
// ----------------------------------------------------------------------------
module idle_gap_frame_ring_receiver_tb;
    import igfr_pkg::*;

    localparam int FRAME_BYTES    = 128;
    localparam int SLOTS          = 8;
    localparam int SETTLE_CYCLES  = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 280;
    localparam int PHASES         = 6;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic              clk;
    logic              rst_n         = 1'b0;
    logic              push          = 1'b0;
    logic [1:0]        opcode        = OP_TICK;
    logic [BYTE_W-1:0] rx_byte       = '0;
    logic              pop           = 1'b0;
    logic              cfg_valid     = 1'b0;
    logic [GAP_W-1:0]  cfg_data      = GAP_RESET;
    logic              full;
    logic              empty;
    logic              got_byte;
    logic [BYTE_W-1:0] frame_byte;
    logic              last_of_frame;
    logic              cfg_ready;

    int                fail_count;
    int                waiting;
    int                stall_cycles  = 0;
    int                item_count    = 0;
    int                push_left     = 0;
    int                pop_left      = 0;
    bit                push_calm     = 1'b0;
    bit                pop_calm      = 1'b0;
    logic [GAP_W-1:0]  cur_gap       = GAP_RESET;
    logic [GAP_W-1:0]  gap_plan [PHASES];

    idle_gap_frame_ring_receiver #(
        .FRAME_BYTES (FRAME_BYTES),
        .SLOTS       (SLOTS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .rx_byte       (rx_byte),
        .empty         (empty),
        .pop           (pop),
        .got_byte      (got_byte),
        .frame_byte    (frame_byte),
        .last_of_frame (last_of_frame),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    igfr_frame_checker #(
        .FRAME_BYTES (FRAME_BYTES),
        .SLOTS       (SLOTS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .rx_byte       (rx_byte),
        .empty         (empty),
        .pop           (pop),
        .got_byte      (got_byte),
        .frame_byte    (frame_byte),
        .last_of_frame (last_of_frame),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .waiting       (waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic draw_wait(inout int left, inout bit calm, output int cycles);
        if (left == 0)
        begin
            calm = ($urandom_range(0, 3) == 0);
            left = $urandom_range(10, 60);
        end
        left   = left - 1;
        cycles = calm ? 0 : $urandom_range(0, 6);
    endtask

    task automatic put_item(input logic [1:0] op, input logic [BYTE_W-1:0] b);
        int cycles;
        draw_wait(push_left, push_calm, cycles);
        if (cycles > 0)
        begin
            push <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
        push    <= 1'b1;
        opcode  <= op;
        rx_byte <= b;
        do @(posedge clk); while (full);
        item_count++;
    endtask

    task automatic wait_quiet();
        push <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_gap(input logic [GAP_W-1:0] v);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_gap = v;
    endtask

    task automatic request_bytes(input int n);
        repeat (n) put_item(OP_POP, BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic feed_frame(input int len, input bit with_pops);
        int k;
        int need;
        for (k = 0; k < len; k++)
        begin
            put_item(OP_BYTE, BYTE_W'($urandom_range(0, 255)));
            if (with_pops && $urandom_range(0, 3) == 0)
                put_item(OP_POP, BYTE_W'($urandom_range(0, 255)));
        end
        need = (cur_gap == 0) ? 1 : int'(cur_gap);
        if (need > 1 && $urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, need - 1))
                put_item(OP_TICK, BYTE_W'($urandom_range(0, 255)));
            put_item(OP_BYTE, BYTE_W'($urandom_range(0, 255)));
        end
        repeat (need) put_item(OP_TICK, BYTE_W'($urandom_range(0, 255)));
        if ($urandom_range(0, 5) == 0)
            put_item(OP_TICK, BYTE_W'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int cycles;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            draw_wait(pop_left, pop_calm, cycles);
            if (cycles > 0)
            begin
                pop <= 1'b0;
                repeat (cycles) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    initial
    begin
        int ph;
        int first;
        int pick;
        gap_plan[0] = 4'd1;
        gap_plan[1] = 4'd15;
        gap_plan[2] = 4'd0;
        gap_plan[3] = GAP_W'($urandom_range(1, 15));
        gap_plan[4] = GAP_W'($urandom_range(0, 15));
        gap_plan[5] = GAP_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        put_item(OP_POP, 8'h00);
        put_item(OP_TICK, 8'h00);
        put_item(OP_UNUSED, 8'hFF);
        put_item(OP_BYTE, 8'h00);
        put_item(OP_BYTE, 8'hFF);
        put_item(OP_POP, 8'hFF);
        repeat (cur_gap) put_item(OP_TICK, 8'hFF);
        put_item(OP_POP, 8'h00);
        put_item(OP_BYTE, 8'h5A);
        put_item(OP_POP, 8'h00);
        repeat (cur_gap) put_item(OP_TICK, 8'h00);
        put_item(OP_POP, 8'h00);
        put_item(OP_POP, 8'h00);
        set_gap(4'd0);
        put_item(OP_BYTE, 8'h81);
        put_item(OP_TICK, 8'h00);
        put_item(OP_POP, 8'h00);
        put_item(OP_POP, 8'h00);

        for (ph = 0; ph < PHASES; ph++)
        begin
            set_gap(gap_plan[ph]);
            first = item_count;
            if (ph == 0)
            begin
                feed_frame(FRAME_BYTES + 3, 1'b0);
                request_bytes(FRAME_BYTES + 3);
            end
            while (item_count - first < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    feed_frame(($urandom_range(0, 79) == 0) ? $urandom_range(120, 135)
                                                            : $urandom_range(1, 10),
                               $urandom_range(0, 5) == 0);
                else if (pick < 82)
                    request_bytes($urandom_range(1, 12));
                else if (pick < 94)
                    repeat ($urandom_range(1, 4))
                        put_item(2'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)));
                else if (cur_gap <= 3)
                begin
                    put_item(OP_POP, BYTE_W'($urandom_range(0, 255)));
                    repeat (SLOTS + 1) feed_frame($urandom_range(1, 3), 1'b0);
                    request_bytes($urandom_range(2, 10));
                end
            end
        end

        wait_quiet();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
